// ===== design/tvp_pkg.sv =====
// Shared types, constants and helpers for the trapezoidal velocity profile block
package tvp_pkg;

    localparam int          FRAC_BITS_DEF = 24;
    localparam logic [63:0] MAX64         = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX48         = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] US_PER_S      = 64'd1000000;
    localparam logic [63:0] UM_PER_MM     = 64'd1000;
    localparam logic [63:0] SEC_PER_MIN   = 64'd60;
    localparam logic [63:0] T_CLAMP       = 64'h4000_0000_0000_0000;
    localparam logic [63:0] PROG_SCALE    = 64'd65536;
    localparam logic [15:0] ACCEL_RST     = 16'd1000;
    localparam logic [19:0] TICK_RST      = 20'd5000;

    localparam logic [0:0]  REG_ACCEL     = 1'b0;
    localparam logic [0:0]  REG_TICK      = 1'b1;

    typedef enum logic [1:0] {
        OP_MUL    = 2'd0,
        OP_MULDIV = 2'd1,
        OP_SQRT   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        SH_NONE  = 2'd0,
        SH_FRAC  = 2'd1,
        SH_FRAC1 = 2'd2
    } t_shift;

    typedef struct packed {
        t_op         op;
        t_shift      sh;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
    } t_arith_req;

    function automatic logic [63:0] sat48(input logic [63:0] v);
        return (v > MAX48) ? MAX48 : v;
    endfunction

    function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
        return (a > (MAX64 - b)) ? MAX64 : (a + b);
    endfunction

endpackage

// ===== design/tvp_if.sv =====
// Channel interfaces: input requests, results and configuration writes
interface tvp_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [31:0] segment_length_um;
    logic [15:0] feedrate;
    logic [31:0] tick_index;

    modport source(output valid, mode, segment_length_um, feedrate, tick_index, input ready);
    modport sink(input valid, mode, segment_length_um, feedrate, tick_index, output ready);
endinterface

interface tvp_out_if;
    logic        valid;
    logic        ready;
    logic [16:0] progress;
    logic [15:0] speed;
    logic [31:0] duration_ticks;
    logic        triangular;
    logic        finished;

    modport source(output valid, progress, speed, duration_ticks, triangular, finished,
                   input ready);
    modport sink(input valid, progress, speed, duration_ticks, triangular, finished,
                 output ready);
endinterface

interface tvp_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [19:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== design/trapezoid_velocity_profile_top.sv =====
// Trapezoidal velocity profile planner and evaluator, top level
//
//  channel  | dir | payload                                              | ready when
//  i_in     | in  | mode, segment_length_um, feedrate, tick_index       | sequencer idle
//  o_res    | out | progress, speed, duration_ticks, triangular, finished| registered output
//  i_cfg    | in  | index, data (acceleration, tick_period_us)          | always
//
//  One request at a time through one bit-serial arithmetic unit, which runs each
//  multiply, multiply-divide and square root of a plan or tick request in turn.
//  Reset is synchronous, active low; no clearing pass is needed.
//  A finished result waits in the output register while the next request is taken.
module trapezoid_velocity_profile_top #(
    parameter int FRAC_BITS = tvp_pkg::FRAC_BITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tvp_in_if.sink    i_in,
    tvp_out_if.source o_res,
    tvp_cfg_if.sink   i_cfg
);

    localparam logic [63:0] ONE     = 64'd1 << FRAC_BITS;
    localparam logic [63:0] TWO_ONE = 64'd1 << (FRAC_BITS + 1);

    typedef enum logic [22:0] {
        ST_IDLE  = 23'h000001,
        ST_TQ    = 23'h000002,
        ST_LEN   = 23'h000004,
        ST_FEED  = 23'h000008,
        ST_D1    = 23'h000010,
        ST_RATIO = 23'h000020,
        ST_XTRI  = 23'h000040,
        ST_SQRT  = 23'h000080,
        ST_NDIV  = 23'h000100,
        ST_QMUL  = 23'h000200,
        ST_FCALC = 23'h000400,
        ST_ARATE = 23'h000800,
        ST_DRATE = 23'h001000,
        ST_TT    = 23'h002000,
        ST_TA1   = 23'h004000,
        ST_TA2   = 23'h008000,
        ST_TP1   = 23'h010000,
        ST_TP2   = 23'h020000,
        ST_TD1   = 23'h040000,
        ST_TD2   = 23'h080000,
        ST_PROG  = 23'h100000,
        ST_SPEED = 23'h200000,
        ST_OUT   = 23'h400000
    } t_state;

    t_state      r_state;
    logic        r_issued;
    logic [15:0] r_accel;
    logic [19:0] r_tick;

    logic [47:0] r_accel_time;
    logic [47:0] r_cruise_time;
    logic [47:0] r_decel_time;
    logic [47:0] r_accel_rate;
    logic [47:0] r_decel_rate;
    logic [47:0] r_cruise_speed;
    logic [47:0] r_planned_length;
    logic [31:0] r_planned_ticks;

    logic        r_mode;
    logic [31:0] r_len;
    logic [15:0] r_feed;
    logic [31:0] r_idx;

    logic [63:0] r_tq;
    logic [47:0] r_l;
    logic [63:0] r_fm;
    logic [47:0] r_d1;
    logic [47:0] r_d2;
    logic [47:0] r_dm;
    logic [63:0] r_tot;
    logic [31:0] r_n;
    logic        r_tri;
    logic        r_dec;
    logic [63:0] r_t;
    logic [63:0] r_s;
    logic [63:0] r_r;
    logic [63:0] r_sd;
    logic [16:0] r_prog;
    logic [15:0] r_spd;
    logic        r_fin;

    logic        r_ovalid;
    logic [16:0] r_o_progress;
    logic [15:0] r_o_speed;
    logic [31:0] r_o_duration;
    logic        r_o_tri;
    logic        r_o_fin;

    tvp_pkg::t_arith_req n_req;
    logic        n_start;
    logic        n_done;
    logic [63:0] n_res;
    logic [63:0] n_res48;
    logic        n_ack;
    logic [63:0] n_acc1;
    logic [63:0] n_tp1;
    logic [63:0] n_feed1;
    logic [63:0] n_t1;
    logic [63:0] n_t2;
    logic [63:0] n_t3;
    logic [63:0] n_f;
    logic [63:0] n_u;
    logic [63:0] n_pl;
    logic [63:0] n_rmin;
    logic [63:0] n_tc;
    logic [63:0] n_ratio;
    logic [63:0] n_dq;
    logic [63:0] n_d2_sat;
    logic [63:0] n_dm_sat;

    assign n_acc1  = {48'd0, ((r_accel == '0) ? 16'd1 : r_accel)};
    assign n_tp1   = {44'd0, ((r_tick == '0) ? 20'd1 : r_tick)};
    assign n_feed1 = {48'd0, ((r_feed == '0) ? 16'd1 : r_feed)};
    assign n_t1    = {16'd0, r_accel_time};
    assign n_t2    = n_t1 + {16'd0, r_cruise_time};
    assign n_t3    = n_t2 + {16'd0, r_decel_time};
    assign n_f     = {16'd0, r_cruise_speed};
    assign n_u     = r_t - n_t2;
    assign n_pl    = {16'd0, r_planned_length};
    assign n_rmin  = (r_r > n_pl) ? n_pl : r_r;
    assign n_res48 = tvp_pkg::sat48(n_res);
    assign n_tc    = (n_res > tvp_pkg::T_CLAMP) ? tvp_pkg::T_CLAMP : n_res;
    assign n_ratio = n_res48;
    assign n_dq    = (n_res48 > r_tot) ? (n_res48 - r_tot) : 64'd0;
    assign n_d2_sat = tvp_pkg::sat48({16'd0, r_d1} + n_dq);
    assign n_dm_sat = tvp_pkg::sat48({16'd0, r_dm} + n_dq);
    assign n_ack   = r_issued && n_done;

    always_comb begin
        n_req.op = tvp_pkg::OP_MULDIV;
        n_req.sh = tvp_pkg::SH_NONE;
        n_req.a  = '0;
        n_req.b  = '0;
        n_req.c  = '0;
        unique case (r_state)
            ST_TQ: begin
                n_req.a = n_tp1; n_req.b = ONE; n_req.c = tvp_pkg::US_PER_S;
            end
            ST_LEN: begin
                n_req.a = {32'd0, r_len}; n_req.b = ONE; n_req.c = tvp_pkg::UM_PER_MM;
            end
            ST_FEED: begin
                n_req.a = n_feed1; n_req.b = ONE; n_req.c = tvp_pkg::SEC_PER_MIN;
            end
            ST_D1: begin
                n_req.a = r_fm; n_req.b = 64'd1; n_req.c = n_acc1;
            end
            ST_RATIO: begin
                n_req.a = {16'd0, r_l}; n_req.b = ONE; n_req.c = r_fm;
            end
            ST_XTRI: begin
                n_req.a = {16'd0, r_l}; n_req.b = ONE; n_req.c = n_acc1;
            end
            ST_SQRT: begin
                n_req.op = tvp_pkg::OP_SQRT; n_req.a = r_tot; n_req.b = ONE;
            end
            ST_NDIV: begin
                n_req.a = r_tot; n_req.b = 64'd1; n_req.c = r_tq;
            end
            ST_QMUL: begin
                n_req.op = tvp_pkg::OP_MUL; n_req.a = {32'd0, r_n}; n_req.b = r_tq;
            end
            ST_FCALC: begin
                n_req.a = {16'd0, r_l};
                n_req.b = r_tri ? TWO_ONE : ONE;
                n_req.c = r_tri ? ({16'd0, r_d1} + {16'd0, r_d2})
                                : ({16'd0, r_d1} + {16'd0, r_dm});
            end
            ST_ARATE: begin
                n_req.a = r_fm; n_req.b = ONE; n_req.c = {16'd0, r_d1};
            end
            ST_DRATE: begin
                n_req.a = r_fm; n_req.b = ONE; n_req.c = {16'd0, r_d2};
            end
            ST_TT: begin
                n_req.op = tvp_pkg::OP_MUL; n_req.a = {32'd0, r_idx}; n_req.b = r_tq;
            end
            ST_TA1: begin
                n_req.op = tvp_pkg::OP_MUL; n_req.sh = tvp_pkg::SH_FRAC;
                n_req.a = {16'd0, r_accel_rate}; n_req.b = r_t;
            end
            ST_TA2: begin
                n_req.op = tvp_pkg::OP_MUL; n_req.sh = tvp_pkg::SH_FRAC1;
                n_req.a = r_s; n_req.b = r_t;
            end
            ST_TP1: begin
                n_req.op = tvp_pkg::OP_MUL; n_req.sh = tvp_pkg::SH_FRAC1;
                n_req.a = n_f; n_req.b = n_t1;
            end
            ST_TP2: begin
                n_req.op = tvp_pkg::OP_MUL; n_req.sh = tvp_pkg::SH_FRAC;
                n_req.a = n_f; n_req.b = r_t - n_t1;
            end
            ST_TD1: begin
                n_req.op = tvp_pkg::OP_MUL; n_req.sh = tvp_pkg::SH_FRAC;
                n_req.a = {16'd0, r_decel_rate}; n_req.b = n_u;
            end
            ST_TD2: begin
                n_req.op = tvp_pkg::OP_MUL; n_req.sh = tvp_pkg::SH_FRAC1;
                n_req.a = r_sd; n_req.b = n_u;
            end
            ST_PROG: begin
                n_req.a = n_rmin; n_req.b = tvp_pkg::PROG_SCALE; n_req.c = n_pl;
            end
            ST_SPEED: begin
                n_req.op = tvp_pkg::OP_MUL; n_req.sh = tvp_pkg::SH_FRAC;
                n_req.a = r_s; n_req.b = tvp_pkg::SEC_PER_MIN;
            end
            default: ;
        endcase
    end

    assign n_start = !r_issued && (r_state != ST_IDLE) && (r_state != ST_OUT)
                     && !((r_state == ST_PROG) && (r_planned_length == '0));

    tvp_arith #(
        .FRAC_BITS(FRAC_BITS)
    ) u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (n_start),
        .i_req    (n_req),
        .o_done   (n_done),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_issued         <= 1'b0;
            r_ovalid         <= 1'b0;
            r_accel          <= tvp_pkg::ACCEL_RST;
            r_tick           <= tvp_pkg::TICK_RST;
            r_accel_time     <= '0;
            r_cruise_time    <= '0;
            r_decel_time     <= '0;
            r_accel_rate     <= '0;
            r_decel_rate     <= '0;
            r_cruise_speed   <= '0;
            r_planned_length <= '0;
            r_planned_ticks  <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    tvp_pkg::REG_ACCEL: r_accel <= i_cfg.data[15:0];
                    tvp_pkg::REG_TICK:  r_tick  <= i_cfg.data;
                    default: ;
                endcase
            end
            if (n_start) r_issued <= 1'b1;
            if (n_ack) r_issued <= 1'b0;
            if (o_res.ready) r_ovalid <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_mode  <= i_in.mode;
                        r_len   <= i_in.segment_length_um;
                        r_feed  <= i_in.feedrate;
                        r_idx   <= i_in.tick_index;
                        r_state <= ST_TQ;
                    end
                end
                ST_TQ: if (n_ack) begin
                    r_tq    <= (n_res == '0) ? 64'd1 : n_res;
                    r_state <= r_mode ? ST_TT : ST_LEN;
                end
                ST_LEN: if (n_ack) begin
                    r_l     <= n_res48[47:0];
                    r_state <= ST_FEED;
                end
                ST_FEED: if (n_ack) begin
                    r_fm    <= n_res;
                    r_state <= ST_D1;
                end
                ST_D1: if (n_ack) begin
                    r_d1    <= n_res[47:0];
                    r_state <= ST_RATIO;
                end
                ST_RATIO: if (n_ack) begin
                    if (n_ratio > {16'd0, r_d1}) begin
                        r_tri   <= 1'b0;
                        r_dm    <= n_ratio[47:0] - r_d1;
                        r_tot   <= n_ratio + {16'd0, r_d1};
                        r_state <= ST_NDIV;
                    end else begin
                        r_tri   <= 1'b1;
                        r_state <= ST_XTRI;
                    end
                end
                ST_XTRI: if (n_ack) begin
                    r_tot   <= n_res48;
                    r_state <= ST_SQRT;
                end
                ST_SQRT: if (n_ack) begin
                    r_d1    <= n_res48[47:0];
                    r_tot   <= {n_res48[62:0], 1'b0};
                    r_state <= ST_NDIV;
                end
                ST_NDIV: if (n_ack) begin
                    r_n     <= (n_res >= 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                        : (n_res[31:0] + 32'd1);
                    r_state <= ST_QMUL;
                end
                ST_QMUL: if (n_ack) begin
                    if (r_tri) begin
                        r_d2 <= n_d2_sat[47:0];
                        r_dm <= '0;
                    end else begin
                        r_dm <= n_dm_sat[47:0];
                        r_d2 <= r_d1;
                    end
                    r_state <= ST_FCALC;
                end
                ST_FCALC: if (n_ack) begin
                    r_fm             <= n_res48;
                    r_accel_time     <= r_d1;
                    r_cruise_time    <= r_dm;
                    r_decel_time     <= r_d2;
                    r_cruise_speed   <= n_res48[47:0];
                    r_planned_length <= r_l;
                    r_planned_ticks  <= r_n;
                    r_state          <= ST_ARATE;
                end
                ST_ARATE: if (n_ack) begin
                    r_accel_rate <= n_res48[47:0];
                    r_state      <= ST_DRATE;
                end
                ST_DRATE: if (n_ack) begin
                    r_decel_rate <= n_res48[47:0];
                    r_s          <= r_fm;
                    r_prog       <= '0;
                    r_fin        <= 1'b0;
                    r_state      <= ST_SPEED;
                end
                ST_TT: if (n_ack) begin
                    r_t   <= n_tc;
                    r_fin <= 1'b0;
                    if (n_tc < n_t1) begin
                        r_state <= ST_TA1;
                    end else if (n_tc < n_t2) begin
                        r_dec   <= 1'b0;
                        r_state <= ST_TP1;
                    end else if (n_tc < n_t3) begin
                        r_dec   <= 1'b1;
                        r_state <= ST_TP1;
                    end else begin
                        r_r     <= n_pl;
                        r_s     <= '0;
                        r_fin   <= 1'b1;
                        r_state <= ST_PROG;
                    end
                end
                ST_TA1: if (n_ack) begin
                    r_s     <= n_res;
                    r_state <= ST_TA2;
                end
                ST_TA2: if (n_ack) begin
                    r_r     <= n_res;
                    r_state <= ST_PROG;
                end
                ST_TP1: if (n_ack) begin
                    r_r     <= n_res;
                    r_state <= ST_TP2;
                end
                ST_TP2: if (n_ack) begin
                    r_r     <= tvp_pkg::sadd(r_r, n_res);
                    r_s     <= n_f;
                    r_state <= r_dec ? ST_TD1 : ST_PROG;
                end
                ST_TD1: if (n_ack) begin
                    r_sd    <= n_res;
                    r_state <= ST_TD2;
                end
                ST_TD2: if (n_ack) begin
                    r_r     <= (r_r > n_res) ? (r_r - n_res) : 64'd0;
                    r_s     <= (n_f > r_sd) ? (n_f - r_sd) : 64'd0;
                    r_state <= ST_PROG;
                end
                ST_PROG: begin
                    if (r_planned_length == '0) begin
                        r_prog  <= 17'h10000;
                        r_state <= ST_SPEED;
                    end else if (n_ack) begin
                        r_prog  <= n_res[16:0];
                        r_state <= ST_SPEED;
                    end
                end
                ST_SPEED: if (n_ack) begin
                    r_spd   <= (n_res > 64'hFFFF) ? 16'hFFFF : n_res[15:0];
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid     <= 1'b1;
                        r_o_progress <= r_prog;
                        r_o_speed    <= r_spd;
                        r_o_duration <= r_planned_ticks;
                        r_o_tri      <= (r_cruise_time == '0);
                        r_o_fin      <= r_fin;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_in.ready           = (r_state == ST_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_res.valid          = r_ovalid;
    assign o_res.progress       = r_o_progress;
    assign o_res.speed          = r_o_speed;
    assign o_res.duration_ticks = r_o_duration;
    assign o_res.triangular     = r_o_tri;
    assign o_res.finished       = r_o_fin;

endmodule

// ===== design/tvp_arith.sv =====
// Shared bit-serial unit: multiply with saturating shift, multiply-divide, square root
module tvp_arith #(
    parameter int FRAC_BITS = tvp_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  tvp_pkg::t_arith_req i_req,
    output logic                o_done,
    output logic [63:0]         o_result
);

    typedef enum logic [5:0] {
        U_IDLE  = 6'b000001,
        U_MUL   = 6'b000010,
        U_SHIFT = 6'b000100,
        U_DCHK  = 6'b001000,
        U_DIV   = 6'b010000,
        U_SQRT  = 6'b100000
    } t_ustate;

    t_ustate         r_state;
    tvp_pkg::t_op    r_op;
    tvp_pkg::t_shift r_sh;
    logic [63:0]     r_c;
    logic [127:0]    r_acc;
    logic [127:0]    r_ma;
    logic [63:0]     r_mb;
    logic [66:0]     r_rem;
    logic [63:0]     r_root;
    logic [5:0]      r_cnt;
    logic [63:0]     r_res;
    logic            r_done;

    logic [127:0]    n_mul_acc;
    logic [127:0]    n_shifted;
    logic [63:0]     n_shift_res;
    logic [64:0]     n_dtrial;
    logic            n_dge;
    logic [64:0]     n_ddiff;
    logic [127:0]    n_div_acc;
    logic [66:0]     n_srem;
    logic [66:0]     n_strial;
    logic            n_sge;
    logic [66:0]     n_sdiff;

    always_comb begin
        n_mul_acc = r_mb[0] ? (r_acc + r_ma) : r_acc;
        unique case (r_sh)
            tvp_pkg::SH_FRAC:  n_shifted = r_acc >> FRAC_BITS;
            tvp_pkg::SH_FRAC1: n_shifted = r_acc >> (FRAC_BITS + 1);
            default:           n_shifted = r_acc;
        endcase
        n_shift_res = (|n_shifted[127:64]) ? tvp_pkg::MAX64 : n_shifted[63:0];

        n_dtrial  = {r_acc[127:64], r_acc[63]};
        n_dge     = (n_dtrial >= {1'b0, r_c});
        n_ddiff   = n_dtrial - {1'b0, r_c};
        n_div_acc = {(n_dge ? n_ddiff[63:0] : n_dtrial[63:0]), r_acc[62:0], n_dge};

        n_srem   = {r_rem[64:0], r_acc[127:126]};
        n_strial = {1'b0, r_root, 2'b01};
        n_sge    = (n_srem >= n_strial);
        n_sdiff  = n_srem - n_strial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                U_IDLE: begin
                    if (i_start) begin
                        r_op    <= i_req.op;
                        r_sh    <= i_req.sh;
                        r_c     <= i_req.c;
                        r_acc   <= '0;
                        r_ma    <= {64'd0, i_req.a};
                        r_mb    <= i_req.b;
                        r_cnt   <= '1;
                        r_state <= U_MUL;
                    end
                end
                U_MUL: begin
                    r_acc <= n_mul_acc;
                    r_ma  <= r_ma << 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_cnt <= '1;
                        unique case (r_op)
                            tvp_pkg::OP_MULDIV: r_state <= U_DCHK;
                            tvp_pkg::OP_SQRT: begin
                                r_rem   <= '0;
                                r_root  <= '0;
                                r_state <= U_SQRT;
                            end
                            default: r_state <= U_SHIFT;
                        endcase
                    end
                end
                U_SHIFT: begin
                    r_res   <= n_shift_res;
                    r_done  <= 1'b1;
                    r_state <= U_IDLE;
                end
                U_DCHK: begin
                    if (r_c == '0) begin
                        r_res   <= '0;
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end else if (r_acc[127:64] >= r_c) begin
                        r_res   <= tvp_pkg::MAX64;
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end else begin
                        r_state <= U_DIV;
                    end
                end
                U_DIV: begin
                    r_acc <= n_div_acc;
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_res   <= n_div_acc[63:0];
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end
                end
                U_SQRT: begin
                    r_rem  <= n_sge ? n_sdiff : n_srem;
                    r_root <= {r_root[62:0], n_sge};
                    r_acc  <= r_acc << 2;
                    r_cnt  <= r_cnt - 6'd1;
                    if (r_cnt == '0) begin
                        r_res   <= {r_root[62:0], n_sge};
                        r_done  <= 1'b1;
                        r_state <= U_IDLE;
                    end
                end
                default: r_state <= U_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ===== design/tvp_checker.sv =====
// Port-level checks for the trapezoidal velocity profile top level
module tvp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [16:0] i_progress,
    input logic [15:0] i_speed,
    input logic        i_finished
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while busy");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_progress)
                                           && $stable(i_speed)))
        else $error("stalled result changed");

    a_progress_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_progress <= 17'h10000))
        else $error("progress beyond one");

    a_finished_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_finished) |-> (i_progress == 17'h10000))
        else $error("finished without full progress");

    a_finished_still: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_finished) |-> (i_speed == 16'd0))
        else $error("finished with nonzero speed");

endmodule

bind trapezoid_velocity_profile_top tvp_checker u_tvp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_progress  (o_res.progress),
    .i_speed     (o_res.speed),
    .i_finished  (o_res.finished)
);

// ===== sim/trapezoid_velocity_profile_top_tb.sv =====
// Self-checking testbench for the trapezoidal velocity profile planner and evaluator
`timescale 1ns / 100ps

module trapezoid_velocity_profile_top_tb;

    localparam int          FB       = tvp_pkg::FRAC_BITS_DEF;
    localparam logic [63:0] ONE      = 64'd1 << FB;
    localparam int          N_RANDOM = 260;
    localparam longint      LIMIT    = 12_000_000;

    typedef struct packed {
        logic [16:0] progress;
        logic [15:0] speed;
        logic [31:0] duration_ticks;
        logic        triangular;
        logic        finished;
    } t_result;

    typedef struct packed {
        logic        mode;
        logic [31:0] len_um;
        logic [15:0] feed;
        logic [31:0] tick;
        logic        typed;
        t_result     res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    tvp_in_if  in_ch();
    tvp_out_if res_ch();
    tvp_cfg_if cfg_ch();

    trapezoid_velocity_profile_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_res   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // predictor state
    logic [63:0] pr_accel, pr_tick_us;
    logic [63:0] pr_t_acc, pr_t_cru, pr_t_dec, pr_r_acc, pr_r_dec, pr_v_cru, pr_len;
    logic [31:0] pr_ticks;

    t_result expected_q[$];
    int      err_cnt;
    int      req_cnt;
    int      cfg_cnt;
    int      snd_idle_pct;
    int      rcv_idle_pct;
    logic    fix_on;
    t_result fix_res;
    longint  cyc;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] mul_sh(input logic [63:0] a, input logic [63:0] b,
                                           input int sh);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        return (p[127:64] != 0) ? tvp_pkg::MAX64 : p[63:0];
    endfunction

    function automatic logic [63:0] mul_dv(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] c);
        logic [127:0] p;
        logic [127:0] q;
        if (c == 0) begin
            return 64'd0;
        end
        p = {64'd0, a} * {64'd0, b};
        if (p[127:64] >= c) begin
            return tvp_pkg::MAX64;
        end
        q = p / {64'd0, c};
        return q[63:0];
    endfunction

    function automatic logic [63:0] root_q(input logic [63:0] x);
        logic [127:0] n;
        logic [63:0]  r;
        logic [63:0]  c;
        n = {64'd0, x} << FB;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n) begin
                r = c;
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] tick_len_q();
        logic [63:0] tp;
        logic [63:0] q;
        tp = (pr_tick_us != 0) ? pr_tick_us : 64'd1;
        q  = mul_dv(tp, ONE, tvp_pkg::US_PER_S);
        return (q != 0) ? q : 64'd1;
    endfunction

    task automatic quantise_time(input logic [63:0] total, input logic [63:0] tq,
                                 output logic [63:0] added);
        logic [63:0] n;
        logic [63:0] q;
        n = total / tq;
        n = (n >= 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : n + 1;
        pr_ticks = n[31:0];
        q = tvp_pkg::sat48(mul_sh(n, tq, 0));
        added = (q > total) ? q - total : 64'd0;
    endtask

    task automatic plan_segment(input logic [63:0] len_um, input logic [63:0] feed_in);
        logic [63:0] acc, tq, l, fm, d1, d2, dm, ratio, dq, feed;
        acc  = (pr_accel != 0) ? pr_accel : 64'd1;
        feed = (feed_in != 0) ? feed_in : 64'd1;
        tq   = tick_len_q();
        l     = tvp_pkg::sat48(mul_dv(len_um, ONE, tvp_pkg::UM_PER_MM));
        fm    = mul_dv(feed, ONE, tvp_pkg::SEC_PER_MIN);
        d1    = fm / acc;
        ratio = tvp_pkg::sat48(mul_dv(l, ONE, fm));
        if (ratio > d1) begin
            dm = ratio - d1;
            quantise_time(ratio + d1, tq, dq);
            dm = tvp_pkg::sat48(dm + dq);
            d2 = d1;
            fm = mul_dv(l, ONE, d1 + dm);
        end else begin
            d1 = tvp_pkg::sat48(root_q(tvp_pkg::sat48(mul_dv(l, ONE, acc))));
            quantise_time(2 * d1, tq, dq);
            d2 = tvp_pkg::sat48(d1 + dq);
            dm = 0;
            fm = mul_dv(l, 2 * ONE, d1 + d2);
        end
        fm       = tvp_pkg::sat48(fm);
        pr_t_acc = d1;
        pr_t_cru = dm;
        pr_t_dec = d2;
        pr_v_cru = fm;
        pr_r_acc = tvp_pkg::sat48(mul_dv(fm, ONE, d1));
        pr_r_dec = tvp_pkg::sat48(mul_dv(fm, ONE, d2));
        pr_len   = l;
    endtask

    task automatic calc_profile(input logic mode, input logic [31:0] len_um,
                                input logic [15:0] feed, input logic [31:0] tick,
                                output t_result res);
        logic [63:0] t, t1, t2, t3, f, u, pos, sd, neg, r, s, prog;
        logic        fin;
        r   = 0;
        s   = 0;
        fin = 1'b0;
        if (mode == 1'b0) begin
            plan_segment({32'd0, len_um}, {48'd0, feed});
            s = mul_sh(pr_v_cru, tvp_pkg::SEC_PER_MIN, FB);
            res.progress       = '0;
            res.speed          = (s > 64'hFFFF) ? 16'hFFFF : s[15:0];
            res.duration_ticks = pr_ticks;
            res.triangular     = (pr_t_cru == 0);
            res.finished       = 1'b0;
        end else begin
            t  = mul_sh({32'd0, tick}, tick_len_q(), 0);
            t1 = pr_t_acc;
            t2 = t1 + pr_t_cru;
            t3 = t2 + pr_t_dec;
            f  = pr_v_cru;
            if (t > tvp_pkg::T_CLAMP) begin
                t = tvp_pkg::T_CLAMP;
            end
            if (t < t1) begin
                s = mul_sh(pr_r_acc, t, FB);
                r = mul_sh(s, t, FB + 1);
            end else if (t < t2) begin
                r = tvp_pkg::sadd(mul_sh(f, t1, FB + 1), mul_sh(f, t - t1, FB));
                s = f;
            end else if (t < t3) begin
                u   = t - t2;
                pos = tvp_pkg::sadd(mul_sh(f, t1, FB + 1), mul_sh(f, t - t1, FB));
                sd  = mul_sh(pr_r_dec, u, FB);
                neg = mul_sh(sd, u, FB + 1);
                r   = (pos > neg) ? pos - neg : 64'd0;
                s   = (f > sd) ? f - sd : 64'd0;
            end else begin
                r   = pr_len;
                s   = 0;
                fin = 1'b1;
            end
            if (pr_len == 0) begin
                prog = tvp_pkg::PROG_SCALE;
            end else begin
                if (r > pr_len) begin
                    r = pr_len;
                end
                prog = mul_dv(r, tvp_pkg::PROG_SCALE, pr_len);
            end
            s = mul_sh(s, tvp_pkg::SEC_PER_MIN, FB);
            res.progress       = prog[16:0];
            res.speed          = (s > 64'hFFFF) ? 16'hFFFF : s[15:0];
            res.duration_ticks = pr_ticks;
            res.triangular     = (pr_t_cru == 0);
            res.finished       = fin;
        end
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result calc;
        cyc++;
        if (cyc > LIMIT) begin
            $display("trapezoid_velocity_profile_top_tb: done, errors");
            $finish;
        end else if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                got = '{res_ch.progress, res_ch.speed, res_ch.duration_ticks,
                        res_ch.triangular, res_ch.finished};
                if (expected_q.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.progress != want.progress)
                        report("progress", got.progress, want.progress);
                    if (got.speed != want.speed)
                        report("speed", got.speed, want.speed);
                    if (got.duration_ticks != want.duration_ticks)
                        report("duration_ticks", got.duration_ticks, want.duration_ticks);
                    if (got.triangular != want.triangular)
                        report("triangular", got.triangular, want.triangular);
                    if (got.finished != want.finished)
                        report("finished", got.finished, want.finished);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                calc_profile(in_ch.mode, in_ch.segment_length_um, in_ch.feedrate,
                             in_ch.tick_index, calc);
                expected_q.push_back(fix_on ? fix_res : calc);
                req_cnt++;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.index == tvp_pkg::REG_ACCEL)
                    pr_accel = {48'd0, cfg_ch.data[15:0]};
                else
                    pr_tick_us = {44'd0, cfg_ch.data};
                cfg_cnt++;
            end
        end
    end

    always @(negedge i_clk) begin
        res_ch.ready <= !i_rst_n || ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // entered and left at a falling edge
    task automatic send_req(input logic mode, input logic [31:0] len_um,
                            input logic [15:0] feed, input logic [31:0] tick,
                            input logic typed, input t_result res);
        int n;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid             <= 1'b1;
        in_ch.mode              <= mode;
        in_ch.segment_length_um <= len_um;
        in_ch.feedrate          <= feed;
        in_ch.tick_index        <= tick;
        fix_on                  <= typed;
        fix_res                 <= res;
        n = req_cnt;
        do @(negedge i_clk); while (req_cnt == n);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [19:0] val);
        int n;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        n = cfg_cnt;
        do @(negedge i_clk); while (cfg_cnt == n);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic random_req();
        logic [63:0] span;
        logic [31:0] len_um;
        logic [31:0] tick;
        logic [15:0] feed;
        int          k;
        if ($urandom_range(0, 5) == 0) begin
            k = $urandom_range(0, 9);
            len_um = (k < 7) ? $urandom_range(0, 200000) :
                     (k < 9) ? $urandom_range(0, 32'h00FF_FFFF) : $urandom;
            k = $urandom_range(0, 9);
            feed = (k == 0) ? 16'd1 : (k == 1) ? 16'hFFFF : 16'($urandom_range(1, 65535));
            send_req(1'b0, len_um, feed, '0, 1'b0, '0);
        end else begin
            k    = $urandom_range(0, 9);
            span = {32'd0, pr_ticks} + {32'd0, pr_ticks} / 8 + 2;
            if (span > 64'hFFFF_FFFF)
                span = 64'hFFFF_FFFF;
            tick = (k < 8) ? $urandom_range(0, span[31:0]) :
                   (k == 8) ? $urandom : pr_ticks + $urandom_range(0, 2) - 1;
            send_req(1'b1, $urandom, 16'($urandom), tick, 1'b0, '0);
        end
    endtask

    t_row rows[] = '{
        '{1'b1, 32'd0, 16'd0, 32'd0, 1'b1, '{17'd65536, 16'd0, 32'd0, 1'b1, 1'b1}},
        '{1'b0, 32'd0, 16'd1000, 32'd0, 1'b1, '{17'd0, 16'd0, 32'd1, 1'b1, 1'b0}},
        '{1'b1, 32'd0, 16'd0, 32'd0, 1'b1, '{17'd65536, 16'd0, 32'd1, 1'b1, 1'b0}},
        '{1'b1, 32'd0, 16'd0, 32'hFFFF_FFFF, 1'b1, '{17'd65536, 16'd0, 32'd1, 1'b1, 1'b1}},
        '{1'b0, 32'd10000, 16'd3000, 32'd0, 1'b0, '0},
        '{1'b1, 32'd0, 16'd0, 32'd0, 1'b0, '0},
        '{1'b1, 32'd0, 16'd0, 32'd10, 1'b0, '0},
        '{1'b1, 32'd0, 16'd0, 32'd50, 1'b0, '0},
        '{1'b1, 32'd0, 16'd0, 32'd100, 1'b0, '0},
        '{1'b1, 32'd0, 16'd0, 32'd1000, 1'b0, '0},
        '{1'b1, 32'd0, 16'd0, 32'hFFFF_FFFF, 1'b0, '0},
        '{1'b0, 32'hFFFF_FFFF, 16'hFFFF, 32'd0, 1'b0, '0},
        '{1'b1, 32'd0, 16'd0, 32'd0, 1'b0, '0},
        '{1'b1, 32'd0, 16'd0, 32'd1000, 1'b0, '0},
        '{1'b1, 32'd0, 16'd0, 32'hFFFF_FFFF, 1'b0, '0},
        '{1'b0, 32'd1, 16'd1, 32'd0, 1'b0, '0},
        '{1'b1, 32'd0, 16'd0, 32'd0, 1'b0, '0},
        '{1'b1, 32'd0, 16'd0, 32'd1, 1'b0, '0},
        '{1'b0, 32'd500, 16'hFFFF, 32'd0, 1'b0, '0},
        '{1'b1, 32'd0, 16'd0, 32'd1, 1'b0, '0},
        '{1'b1, 32'd0, 16'd0, 32'd3, 1'b0, '0},
        '{1'b1, 32'd0, 16'd0, 32'd6, 1'b0, '0},
        '{1'b1, 32'd0, 16'd0, 32'd100, 1'b0, '0}
    };

    initial begin
        err_cnt      = 0;
        req_cnt      = 0;
        cfg_cnt      = 0;
        cyc          = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        pr_accel     = {48'd0, tvp_pkg::ACCEL_RST};
        pr_tick_us   = {44'd0, tvp_pkg::TICK_RST};
        {pr_t_acc, pr_t_cru, pr_t_dec, pr_r_acc, pr_r_dec, pr_v_cru, pr_len} = '0;
        pr_ticks     = '0;
        fix_on       = 1'b0;
        fix_res      = '0;
        i_rst_n      = 1'b0;
        in_ch.valid             = 1'b0;
        in_ch.mode              = 1'b0;
        in_ch.segment_length_um = '0;
        in_ch.feedrate          = '0;
        in_ch.tick_index        = '0;
        res_ch.ready = 1'b1;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = tvp_pkg::REG_ACCEL;
        cfg_ch.data  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (rows[i])
            send_req(rows[i].mode, rows[i].len_um, rows[i].feed, rows[i].tick,
                     rows[i].typed, rows[i].res);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    snd_idle_pct = 0;  rcv_idle_pct = 0;
                    write_reg(tvp_pkg::REG_ACCEL, 20'd1000);
                    write_reg(tvp_pkg::REG_TICK, 20'd5000);
                end
                1: begin
                    snd_idle_pct = 49; rcv_idle_pct = 0;
                    write_reg(tvp_pkg::REG_ACCEL, 20'd65535);
                    write_reg(tvp_pkg::REG_TICK, 20'd1);
                end
                2: begin
                    snd_idle_pct = 0;  rcv_idle_pct = 49;
                    write_reg(tvp_pkg::REG_ACCEL, 20'd1);
                    write_reg(tvp_pkg::REG_TICK, 20'd1000000);
                end
                default: begin
                    snd_idle_pct = 6;  rcv_idle_pct = 6;
                    write_reg(tvp_pkg::REG_ACCEL, 20'($urandom_range(1, 65535)));
                    write_reg(tvp_pkg::REG_TICK, 20'($urandom_range(1, 1000000)));
                end
            endcase
            for (int n = 0; n < N_RANDOM; n++) begin
                if (ph == 1 && n == N_RANDOM / 2)
                    drain();
                random_req();
            end
            drain();
        end

        if (err_cnt == 0)
            $display("trapezoid_velocity_profile_top_tb: done, clean");
        else
            $display("trapezoid_velocity_profile_top_tb: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
design/tvp_pkg.sv
design/tvp_if.sv
design/tvp_arith.sv
design/trapezoid_velocity_profile_top.sv
design/tvp_checker.sv
sim/trapezoid_velocity_profile_top_tb.sv
